// ----- src/parabola_envelope_distance_1d_assert.svh -----
// Assertion macros for the parabola envelope distance block.
`ifndef PARABOLA_ENVELOPE_DISTANCE_1D_ASSERT_SVH
`define PARABOLA_ENVELOPE_DISTANCE_1D_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PEDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PEDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pedt_pkg.sv -----
// Shared constants for the parabola envelope distance block.
package pedt_pkg;

    localparam int LINE_LENGTH   = 64;
    localparam int FRACTION_BITS = 16;

    localparam int SAMPLE_W = 24;
    localparam int IDX_W    = $clog2(LINE_LENGTH);
    localparam int BND_W    = 48;
    localparam int DIST_W   = 25;
    // magnitude of (f_q+q^2)-(f_v+v^2)
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int NUM_W    = MAG_W + 1;
    localparam int DVD_W    = MAG_W + FRACTION_BITS;
    localparam int DEN_W    = IDX_W + 1;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int STK_W    = IDX_W + BND_W;

    localparam logic [BND_W-1:0] NEG_INF = {1'b1, {(BND_W-1){1'b0}}};

endpackage

// ----- src/parabola_envelope_distance_1d.sv -----
// Sample 0 is pushed directly; each later one takes one intersection, plus one per pop.
// Output pass: per result the cursor steps up the envelope; a result holds until taken.
// Throughput: one sample per transaction; a line of n samples ends in n results.
// Rate is set by the 41-step bit-serial divider and the single read port of each memory.
// Reset: asynchronous, active low; clears the sequencer, line count and envelope top.
// Sample and envelope memories are not cleared; each entry is written before it is used.
module parabola_envelope_distance_1d
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pedt_pkg::SAMPLE_W-1:0]  sample,
    input  logic                           is_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pedt_pkg::DIST_W-1:0]    distance,
    output logic [pedt_pkg::IDX_W-1:0]     basin,
    output logic                           end_of_line
);

    // One-hot sequencer. The build states pop and push the envelope, the P_ states
    // walk it for the output pass.
    typedef enum logic [10:0]
    {
        S_IDLE     = 11'b000_0000_0001,
        S_RD_TOP   = 11'b000_0000_0010,
        S_RD_F     = 11'b000_0000_0100,
        S_DIV_GO   = 11'b000_0000_1000,
        S_DIV_WAIT = 11'b000_0001_0000,
        S_CMP      = 11'b000_0010_0000,
        S_P_RD     = 11'b000_0100_0000,
        S_P_CMP    = 11'b000_1000_0000,
        S_P_FV     = 11'b001_0000_0000,
        S_P_OUT    = 11'b010_0000_0000,
        S_P_HOLD   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Line and envelope control
    logic [pedt_pkg::IDX_W-1:0]    q_reg, q_next;       // current sample position
    logic [pedt_pkg::IDX_W-1:0]    top_reg, top_next;   // envelope top
    logic [pedt_pkg::IDX_W-1:0]    k_reg, k_next;       // envelope cursor
    logic [pedt_pkg::IDX_W-1:0]    pos_reg, pos_next;   // output position
    logic                          last_reg, last_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload
    logic [pedt_pkg::SAMPLE_W-1:0] fq_reg;
    logic [pedt_pkg::IDX_W-1:0]    v_reg, v_next;
    logic [pedt_pkg::BND_W-1:0]    b_reg, b_next;
    logic [pedt_pkg::BND_W-1:0]    s_reg, s_next;
    logic [pedt_pkg::IDX_W-1:0]    cur_v_reg, cur_v_next;
    logic [pedt_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic [pedt_pkg::IDX_W-1:0]    basin_reg, basin_next;
    logic                          eol_reg, eol_next;

    // Sample memory
    logic [pedt_pkg::SAMPLE_W-1:0] samp_mem [pedt_pkg::LINE_LENGTH];
    logic                          samp_we;
    logic [pedt_pkg::IDX_W-1:0]    samp_raddr;
    logic [pedt_pkg::SAMPLE_W-1:0] samp_rdata_reg;

    // Envelope memory: {vertex, lower boundary}
    logic [pedt_pkg::STK_W-1:0]    stk_mem [pedt_pkg::LINE_LENGTH];
    logic                          stk_we;
    logic [pedt_pkg::IDX_W-1:0]    stk_waddr;
    logic [pedt_pkg::STK_W-1:0]    stk_wdata;
    logic [pedt_pkg::IDX_W-1:0]    stk_raddr;
    logic [pedt_pkg::STK_W-1:0]    stk_rdata_reg;

    // Divider
    logic                          div_start;
    logic [pedt_pkg::DVD_W-1:0]    div_dividend;
    logic [pedt_pkg::DEN_W-1:0]    div_divisor;
    logic                          div_busy;
    logic                          div_done;
    logic [pedt_pkg::DVD_W-1:0]    div_quo;
    logic                          div_rem_nz;

    // Intersection numerator terms
    logic [pedt_pkg::NUM_W-1:0]    lhs_term;
    logic [pedt_pkg::NUM_W-1:0]    rhs_term;
    logic [pedt_pkg::NUM_W-1:0]    num;
    logic                          num_neg;
    logic [pedt_pkg::NUM_W-1:0]    num_abs;
    logic                          num_neg_reg;

    // Output pass terms
    logic [pedt_pkg::IDX_W-1:0]    dq;
    logic [2*pedt_pkg::IDX_W-1:0]  dq_sq;
    logic [pedt_pkg::BND_W-1:0]    pos_scaled;
    logic [pedt_pkg::BND_W-1:0]    mag_ext;

    logic                          in_fire;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // (f_q + q^2) - (f_v + v^2); f_v arrives from the sample memory
    assign lhs_term = pedt_pkg::NUM_W'(fq_reg) + pedt_pkg::NUM_W'(q_reg * q_reg);
    assign rhs_term = pedt_pkg::NUM_W'(samp_rdata_reg) + pedt_pkg::NUM_W'(v_reg * v_reg);
    assign num      = lhs_term - rhs_term;
    assign num_neg  = num[pedt_pkg::NUM_W-1];
    assign num_abs  = num_neg ? (~num + 1'b1) : num;

    assign div_start    = (state_reg == S_DIV_GO);
    assign div_dividend = {num_abs[pedt_pkg::MAG_W-1:0], {pedt_pkg::FRACTION_BITS{1'b0}}};
    assign div_divisor  = {q_reg - v_reg, 1'b0};

    // Negative quotients round toward minus infinity: add one if inexact.
    assign mag_ext = pedt_pkg::BND_W'(div_quo) + pedt_pkg::BND_W'(div_rem_nz && num_neg_reg);

    assign dq         = (pos_reg > cur_v_reg) ? (pos_reg - cur_v_reg) : (cur_v_reg - pos_reg);
    assign dq_sq      = dq * dq;
    assign pos_scaled = pedt_pkg::BND_W'({pos_reg, {pedt_pkg::FRACTION_BITS{1'b0}}});

    pedt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        top_next       = top_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        v_next         = v_reg;
        b_next         = b_reg;
        s_next         = s_reg;
        cur_v_next     = cur_v_reg;
        dist_next      = dist_reg;
        basin_next     = basin_reg;
        eol_next       = eol_reg;
        samp_we        = 1'b0;
        samp_raddr     = cur_v_reg;
        stk_we         = 1'b0;
        stk_waddr      = '0;
        stk_wdata      = {{pedt_pkg::IDX_W{1'b0}}, pedt_pkg::NEG_INF};
        stk_raddr      = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    samp_we   = 1'b1;
                    last_next = is_last || (q_reg == pedt_pkg::IDX_W'(pedt_pkg::LINE_LENGTH - 1));
                    k_next    = top_reg;
                    if (q_reg == '0)
                    begin
                        // first position: bottom entry with boundary at minus infinity
                        stk_we     = 1'b1;
                        top_next   = '0;
                        k_next     = '0;
                        pos_next   = '0;
                        cur_v_next = '0;
                        q_next     = pedt_pkg::IDX_W'(!is_last);
                        state_next = (is_last) ? S_P_RD : S_IDLE;
                        last_next  = is_last;
                    end
                    else
                    begin
                        state_next = S_RD_TOP;
                    end
                end
            end
            S_RD_TOP:
            begin
                stk_raddr  = k_reg;
                state_next = S_RD_F;
            end
            S_RD_F:
            begin
                v_next     = stk_rdata_reg[pedt_pkg::STK_W-1:pedt_pkg::BND_W];
                b_next     = stk_rdata_reg[pedt_pkg::BND_W-1:0];
                samp_raddr = stk_rdata_reg[pedt_pkg::STK_W-1:pedt_pkg::BND_W];
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    s_next     = num_neg_reg ? (~mag_ext + 1'b1) : mag_ext;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if ((k_reg != '0) && ($signed(s_reg) <= $signed(b_reg)))
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_RD_TOP;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = k_reg + 1'b1;
                    stk_wdata  = {q_reg, s_reg};
                    top_next   = k_reg + 1'b1;
                    // on the line's last sample q stays at the last position
                    q_next     = last_reg ? q_reg : (q_reg + 1'b1);
                    k_next     = '0;
                    pos_next   = '0;
                    cur_v_next = '0;
                    state_next = last_reg ? S_P_RD : S_IDLE;
                end
            end
            S_P_RD:
            begin
                stk_raddr = k_reg + 1'b1;
                if (k_reg < top_reg)
                begin
                    state_next = S_P_CMP;
                end
                else
                begin
                    state_next = S_P_FV;
                end
            end
            S_P_CMP:
            begin
                if ($signed(stk_rdata_reg[pedt_pkg::BND_W-1:0]) < $signed(pos_scaled))
                begin
                    k_next     = k_reg + 1'b1;
                    cur_v_next = stk_rdata_reg[pedt_pkg::STK_W-1:pedt_pkg::BND_W];
                    state_next = S_P_RD;
                end
                else
                begin
                    state_next = S_P_FV;
                end
            end
            S_P_FV:
            begin
                samp_raddr = cur_v_reg;
                state_next = S_P_OUT;
            end
            S_P_OUT:
            begin
                dist_next      = pedt_pkg::DIST_W'(dq_sq) + pedt_pkg::DIST_W'(samp_rdata_reg);
                basin_next     = cur_v_reg;
                // q_reg holds the last position of the line during the pass
                eol_next       = (pos_reg == q_reg);
                out_valid_next = 1'b1;
                state_next     = S_P_HOLD;
            end
            S_P_HOLD:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (eol_reg)
                    begin
                        q_next     = '0;
                        top_next   = '0;
                        k_next     = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_P_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            q_reg         <= '0;
            top_reg       <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_reg         <= q_next;
            top_reg       <= top_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fq_reg <= sample;
        end
        if (div_start)
        begin
            num_neg_reg <= num_neg;
        end
        v_reg     <= v_next;
        b_reg     <= b_next;
        s_reg     <= s_next;
        cur_v_reg <= cur_v_next;
        dist_reg  <= dist_next;
        basin_reg <= basin_next;
        eol_reg   <= eol_next;
    end

    // Sample memory: written on each input transaction, one registered read
    always_ff @(posedge clk)
    begin
        if (samp_we)
        begin
            samp_mem[q_reg] <= sample;
        end
        samp_rdata_reg <= samp_mem[samp_raddr];
    end

    // Envelope memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign distance    = dist_reg;
    assign basin       = basin_reg;
    assign end_of_line = eol_reg;

    `include "parabola_envelope_distance_1d_assert.svh"

    `PEDT_ASSERT_NOW(a_no_input_in_pass, out_valid, !in_ready, "input taken during output pass")
    `PEDT_ASSERT_NOW(a_div_only_waiting, div_busy, (state_reg == S_DIV_WAIT), "divider busy outside wait")
    `PEDT_ASSERT_NOW(a_cursor_in_env, (state_reg == S_P_RD), (k_reg <= top_reg), "cursor past top")
    `PEDT_ASSERT_NEXT(a_eol_returns_idle, out_valid && out_ready && end_of_line, in_ready, "line not closed")

endmodule

// ----- src/pedt_div.sv -----
// Restoring divider, one quotient bit per cycle, for intersection abscissae.
module pedt_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pedt_pkg::DVD_W-1:0]    dividend,
    input  logic [pedt_pkg::DEN_W-1:0]    divisor,
    output logic                          busy,
    output logic                          done,
    output logic [pedt_pkg::DVD_W-1:0]    quotient,
    output logic                          rem_nz
);

    logic [pedt_pkg::DVD_W-1:0]     quo_reg, quo_next;
    logic [pedt_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [pedt_pkg::DEN_W-1:0]     den_reg;
    logic [pedt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [pedt_pkg::DEN_W:0]       trial;
    logic                           ge;

    assign trial = {rem_reg, quo_reg[pedt_pkg::DVD_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = pedt_pkg::DIV_CNT_W'(pedt_pkg::DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? pedt_pkg::DEN_W'(trial - {1'b0, den_reg})
                          : trial[pedt_pkg::DEN_W-1:0];
            quo_next = {quo_reg[pedt_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pedt_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

endmodule

// ----- tb/parabola_envelope_distance_1d_test.sv -----
// Testbench for the parabola envelope distance block: predicts each line and checks every result.
`timescale 1ns / 1ps

module parabola_envelope_distance_1d_test;

    localparam longint POS_INF_CODE = 64'sd140737488355327;
    localparam longint NEG_INF_CODE = -64'sd140737488355328;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     SETTLE_CYCLES = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [pedt_pkg::SAMPLE_W-1:0] sample;
    logic                          is_last;
    logic                          out_valid;
    logic                          out_ready;
    logic [pedt_pkg::DIST_W-1:0]   distance;
    logic [pedt_pkg::IDX_W-1:0]    basin;
    logic                          end_of_line;

    parabola_envelope_distance_1d u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance),
        .basin       (basin),
        .end_of_line (end_of_line)
    );

    // Own copy of the envelope state
    logic [pedt_pkg::SAMPLE_W-1:0] line_cost  [pedt_pkg::LINE_LENGTH];
    logic [pedt_pkg::IDX_W-1:0]    hull_vertex[pedt_pkg::LINE_LENGTH];
    longint                        hull_bound [pedt_pkg::LINE_LENGTH+1];
    int                            hull_top;
    int                            line_fill;

    // Expected results, oldest first
    logic [pedt_pkg::DIST_W-1:0] exp_distance[$];
    logic [pedt_pkg::IDX_W-1:0]  exp_basin[$];
    logic                        exp_eol[$];

    int  mismatches;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Runaway guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    // Floor of the crossing point of the parabolas at q and v, 16 fraction bits
    function automatic longint crossing(input int q, input int v);
        longint num;
        longint den;
        if (q <= v)
            return POS_INF_CODE;
        num = (longint'(line_cost[q]) + q * q) - (longint'(line_cost[v]) + v * v);
        den = 2 * (q - v);
        if (num >= 0)
            return (num <<< pedt_pkg::FRACTION_BITS) / den;
        return -((((-num) <<< pedt_pkg::FRACTION_BITS) + den - 1) / den);
    endfunction

    // Add one accepted sample; on line end push the expected distances, basins and line ends
    task automatic predict_line(input logic [pedt_pkg::SAMPLE_W-1:0] s, input bit last);
        int     q;
        int     k;
        int     n;
        int     v;
        longint cut;
        longint dq;
        q = (line_fill >= pedt_pkg::LINE_LENGTH) ? pedt_pkg::LINE_LENGTH - 1 : line_fill;
        line_cost[q] = s;
        if (q == 0)
        begin
            hull_vertex[0] = '0;
            hull_bound[0]  = NEG_INF_CODE;
            hull_bound[1]  = POS_INF_CODE;
            hull_top       = 0;
        end
        else
        begin
            k   = hull_top;
            cut = crossing(q, hull_vertex[k]);
            while (k > 0 && cut <= hull_bound[k])
            begin
                k--;
                cut = crossing(q, hull_vertex[k]);
            end
            k++;
            hull_vertex[k]  = q[pedt_pkg::IDX_W-1:0];
            hull_bound[k]   = cut;
            hull_bound[k+1] = POS_INF_CODE;
            hull_top        = k;
        end
        n = q + 1;
        line_fill = n;
        if (n >= pedt_pkg::LINE_LENGTH)
            last = 1'b1;
        if (!last)
            return;
        k = 0;
        for (int p = 0; p < n; p++)
        begin
            while (k < hull_top
                   && hull_bound[k+1] < (longint'(p) <<< pedt_pkg::FRACTION_BITS))
                k++;
            v  = hull_vertex[k];
            dq = (p > v) ? p - v : v - p;
            exp_distance.push_back(pedt_pkg::DIST_W'(dq * dq + line_cost[v]));
            exp_basin.push_back(pedt_pkg::IDX_W'(v));
            exp_eol.push_back(p + 1 == n);
        end
        line_fill = 0;
        hull_top  = 0;
    endtask

    // Offer one transaction, with random idle cycles ahead of it
    task automatic send_sample(input logic [pedt_pkg::SAMPLE_W-1:0] s, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = s;
        is_last  = last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_line(s, last);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until every expected result has come, then let the block settle
    task automatic wait_drained();
        while (exp_distance.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [pedt_pkg::SAMPLE_W-1:0] rand_cost();
        case ($urandom_range(5))
            0:       return '0;
            1:       return {pedt_pkg::SAMPLE_W{1'b1}};
            2:       return pedt_pkg::SAMPLE_W'($urandom_range(15));
            3:       return pedt_pkg::SAMPLE_W'($urandom_range(4095));
            default: return pedt_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // One line of the given length; full-length lines without the flag end on their own
    task automatic send_line(input int len, input bit flag_end);
        for (int i = 0; i < len; i++)
            send_sample(rand_cost(), flag_end && (i == len - 1));
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n || recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_distance.size() == 0)
            begin
                report("unexpected result", distance, 0);
            end
            else
            begin
                if (distance !== exp_distance[0])
                    report("distance", distance, exp_distance[0]);
                if (basin !== exp_basin[0])
                    report("basin", basin, exp_basin[0]);
                if (end_of_line !== exp_eol[0])
                    report("end_of_line", end_of_line, exp_eol[0]);
                void'(exp_distance.pop_front());
                void'(exp_basin.pop_front());
                void'(exp_eol.pop_front());
            end
        end
    end

    // Extremes, single-sample lines and short hand-built envelopes
    task automatic test_directed();
        send_sample('0, 1'b1);
        send_sample({pedt_pkg::SAMPLE_W{1'b1}}, 1'b1);
        send_sample({pedt_pkg::SAMPLE_W{1'b1}}, 1'b0);
        send_sample('0, 1'b1);
        send_sample('0, 1'b0);
        send_sample({pedt_pkg::SAMPLE_W{1'b1}}, 1'b1);
        send_sample('0, 1'b0);
        send_sample({pedt_pkg::SAMPLE_W{1'b1}}, 1'b0);
        send_sample('0, 1'b0);
        send_sample({pedt_pkg::SAMPLE_W{1'b1}}, 1'b1);
        // alternating line: costs switch between 24'h555555 and 24'haaaaaa
        for (int i = 0; i < 5; i++)
            send_sample(pedt_pkg::SAMPLE_W'(24'h555555 ^ {24{i[0]}}), i == 4);
        // falling costs keep every sample on the envelope, with no pops
        for (int i = 0; i < 6; i++)
            send_sample(pedt_pkg::SAMPLE_W'(100 - 20 * i), i == 5);
        wait_drained();
    endtask

    // Random lines, mostly short, now and then full-length ones
    task automatic test_random(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(9))
                0:       len = pedt_pkg::LINE_LENGTH;
                1:       len = $urandom_range(pedt_pkg::LINE_LENGTH, 17);
                default: len = $urandom_range(16, 1);
            endcase
            // a full line without the flag must end by itself
            send_line(len, !(len == pedt_pkg::LINE_LENGTH && $urandom_range(1)));
            sent += len;
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering lines
    task automatic test_backpressure();
        send_idle_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000) @(negedge clk);
                recv_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 5; i++)
                    send_line($urandom_range(8, 2), 1'b1);
            end
        join
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample        = '0;
        is_last       = 1'b0;
        out_ready     = 1'b0;
        recv_hold     = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        line_fill     = 0;
        hull_top      = 0;
        send_idle_pct = 26;
        recv_idle_pct = 70;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(90);
        send_idle_pct = 70;
        recv_idle_pct = 26;
        test_random(90);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(90);
        test_backpressure();

        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
